// ===== rtl/gpr_pkg.sv =====
package gpr_pkg;

    localparam int MAX_WIDTH_DEF    = 1024;
    localparam int MAX_CHANNELS_DEF = 4;
    localparam int HEIGHT_LIMIT     = 4096;
    localparam int PIX_W            = 16;
    localparam int OUT_W            = 18;
    localparam int ROW_W            = 12;
    localparam int HGT_W            = 13;
    localparam int CNT_W            = 3;
    localparam int POS_W            = 13;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 13;
    localparam int CFG_WIDTH_W      = 11;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

    localparam logic [4:0][15:0] TAP_WT = {16'd3277, 16'd16384, 16'd26214, 16'd16384, 16'd3277};

    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] lo;
        logic [POS_W-1:0] hi;
    } trig_t;

    typedef struct packed {
        logic       o;
        logic [2:0] e;
        logic [2:0] m;
    } tap1_t;

    typedef struct packed {
        logic [4:0]      co;
        logic [4:0][2:0] ce;
        logic [4:0][2:0] cm;
        logic [4:0]      ro;
        logic [4:0][2:0] re;
        logic [4:0][2:0] rm;
    } tap_t;

    typedef struct packed {
        logic en_a;
        logic en_b;
        logic en_c;
        logic en_d;
    } lane_ctrl_t;

    function automatic trig_t trigger(input logic [13:0] pos, input logic [13:0] size);
        trig_t t;
        logic [13:0] sp1;
        sp1 = size + 14'd1;
        t.hit = 1'b0;
        t.lo  = '0;
        t.hi  = '0;
        if (pos == size - 14'd1) begin
            t.hit = 1'b1;
            t.lo  = POS_W'((size - 14'd2) >> 1);
            t.hi  = POS_W'(sp1 >> 1) - POS_W'(1);
        end else if (pos >= 14'd2 && !pos[0]) begin
            t.hit = 1'b1;
            t.lo  = POS_W'((pos - 14'd2) >> 1);
            t.hi  = POS_W'((pos - 14'd2) >> 1);
        end
        return t;
    endfunction

    function automatic logic [2:0] win_index(input logic signed [15:0] v);
        logic [2:0] r;
        if (v < 16'sd0) begin
            r = 3'd0;
        end else if (v > 16'sd4) begin
            r = 3'd4;
        end else begin
            r = v[2:0];
        end
        return r;
    endfunction

    function automatic tap1_t reflect_tap(input logic signed [15:0] p,
                                          input logic signed [15:0] size,
                                          input logic signed [15:0] pos);
        tap1_t t;
        logic signed [15:0] e;
        logic signed [15:0] m;
        if (p < 16'sd0) begin
            e   = 16'sd0;
            m   = -p;
            t.o = 1'b1;
        end else if (p >= size) begin
            e   = size - 16'sd1;
            m   = (size <<< 1) - p - 16'sd1;
            t.o = 1'b1;
        end else begin
            e   = p;
            m   = p;
            t.o = 1'b0;
        end
        t.e = win_index(e - pos + 16'sd4);
        t.m = win_index(m - pos + 16'sd4);
        return t;
    endfunction

endpackage

// ===== rtl/gaussian_pyramid_reduce.sv =====
// Gaussian pyramid reduce, 5x5 kernel, point reflection at the borders. Pixels
// enter in raster order with up to four unsigned Q8.8 channels, one pixel per
// clock, and the half-size image leaves as signed Q10.8 pixels, each channel
// worked in its own lane. The shared result pipeline delivers one reduced pixel
// per cycle while the output is not stalled, so a pixel that triggers several
// results holds the input until the last issues (two at the last column of an
// even row past row 0 when the width is odd, two on even columns past column 0
// of the last row when the height is odd, up to four at the last pixel of the
// image). Results pass the input register, sequencer window and job registers
// and lane stages a to d. Writing width, height or channel count restarts the
// image at its first pixel; the line memory needs no clearing after reset.
module gaussian_pyramid_reduce #(
    parameter int MAX_WIDTH    = gpr_pkg::MAX_WIDTH_DEF,
    parameter int MAX_CHANNELS = gpr_pkg::MAX_CHANNELS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [gpr_pkg::PIX_W-1:0]            s_chan0_in,
    input  logic [gpr_pkg::PIX_W-1:0]            s_chan1_in,
    input  logic [gpr_pkg::PIX_W-1:0]            s_chan2_in,
    input  logic [gpr_pkg::PIX_W-1:0]            s_chan3_in,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [gpr_pkg::OUT_W-1:0]     m_chan0_out,
    output logic signed [gpr_pkg::OUT_W-1:0]     m_chan1_out,
    output logic signed [gpr_pkg::OUT_W-1:0]     m_chan2_out,
    output logic signed [gpr_pkg::OUT_W-1:0]     m_chan3_out,
    output logic                                 m_last_of_run,
    output logic                                 m_image_done,
    input  logic                                 cfg_wr_en,
    input  logic [gpr_pkg::CFG_IDX_W-1:0]        cfg_wr_index,
    input  logic [gpr_pkg::CFG_DATA_W-1:0]       cfg_wr_data
);

    localparam int PW    = MAX_CHANNELS * gpr_pkg::PIX_W;
    localparam int CB    = $clog2(MAX_WIDTH);
    localparam int WB    = $clog2(MAX_WIDTH + 1);
    localparam int W_RST = (1024 < MAX_WIDTH) ? 1024 : MAX_WIDTH;
    localparam int C_RST = (3 < MAX_CHANNELS) ? 3 : MAX_CHANNELS;
    localparam int RB    = gpr_pkg::ROW_W;

    logic [WB-1:0]               width_reg;
    logic [gpr_pkg::HGT_W-1:0]   height_reg;
    logic [gpr_pkg::CNT_W-1:0]   chans_reg;
    logic [CB-1:0]               col_reg;
    logic [RB-1:0]               row_reg;

    logic                        p_valid_reg;
    logic [PW-1:0]               p_pix_reg;
    logic [CB-1:0]               p_col_reg;
    logic [RB-1:0]               p_row_reg;
    gpr_pkg::trig_t              p_tx_reg;
    gpr_pkg::trig_t              p_ty_reg;

    logic                        va_reg, vb_reg, vc_reg, vd_reg;
    logic [1:0]                  fa_reg, fb_reg, fc_reg, fd_reg;

    logic [3:0][gpr_pkg::PIX_W-1:0] s_in;
    logic [PW-1:0]               pix;
    logic                        accept;
    logic                        cfg_hit;
    logic                        p_take;
    logic                        issue;
    logic                        seq_last;
    logic                        seq_done;
    logic                        rdy_a, rdy_b, rdy_c, rdy_d;
    logic [3:0][PW-1:0]          bank_rd;
    logic [4:0][4:0][PW-1:0]     win;
    gpr_pkg::tap_t               taps;
    gpr_pkg::lane_ctrl_t         lane_ctrl;
    gpr_pkg::trig_t              tx;
    gpr_pkg::trig_t              ty;
    logic signed [gpr_pkg::OUT_W-1:0] lane_q [4];

    assign s_in    = {s_chan3_in, s_chan2_in, s_chan1_in, s_chan0_in};
    assign accept  = s_valid && s_ready;
    assign s_ready = !p_valid_reg || p_take;
    assign cfg_hit = cfg_wr_en && (cfg_wr_index == gpr_pkg::REG_IMAGE_WIDTH
                                || cfg_wr_index == gpr_pkg::REG_IMAGE_HEIGHT
                                || cfg_wr_index == gpr_pkg::REG_CHANNEL_COUNT);

    always_comb begin
        for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
            pix[ch*gpr_pkg::PIX_W +: gpr_pkg::PIX_W] =
                (gpr_pkg::CNT_W'(ch) < chans_reg) ? s_in[ch] : '0;
        end
    end

    assign tx = gpr_pkg::trigger(14'(col_reg), 14'(width_reg));
    assign ty = gpr_pkg::trigger(14'(row_reg), 14'(height_reg));

    always_ff @(posedge aclk) begin
        int wv;
        int hv;
        int cv;
        if (!aresetn) begin
            width_reg  <= WB'(W_RST);
            height_reg <= gpr_pkg::HGT_W'(1024);
            chans_reg  <= gpr_pkg::CNT_W'(C_RST);
        end else if (cfg_wr_en) begin
            wv = int'(cfg_wr_data[gpr_pkg::CFG_WIDTH_W-1:0]);
            hv = int'(cfg_wr_data);
            cv = int'(cfg_wr_data[gpr_pkg::CNT_W-1:0]);
            unique case (cfg_wr_index)
                gpr_pkg::REG_IMAGE_WIDTH: begin
                    width_reg <= WB'((wv < 3) ? 3 : ((wv > MAX_WIDTH) ? MAX_WIDTH : wv));
                end
                gpr_pkg::REG_IMAGE_HEIGHT: begin
                    height_reg <= gpr_pkg::HGT_W'((hv < 3) ? 3 :
                        ((hv > gpr_pkg::HEIGHT_LIMIT) ? gpr_pkg::HEIGHT_LIMIT : hv));
                end
                gpr_pkg::REG_CHANNEL_COUNT: begin
                    chans_reg <= gpr_pkg::CNT_W'((cv < 1) ? 1 :
                        ((cv > MAX_CHANNELS) ? MAX_CHANNELS : cv));
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_hit) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            if (WB'(col_reg) + WB'(1) >= width_reg) begin
                col_reg <= '0;
                row_reg <= (14'(row_reg) + 14'd1 >= 14'(height_reg)) ? '0 : row_reg + RB'(1);
            end else begin
                col_reg <= col_reg + CB'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (s_ready) begin
            p_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p_pix_reg <= pix;
            p_col_reg <= col_reg;
            p_row_reg <= row_reg;
            p_tx_reg  <= tx;
            p_ty_reg  <= ty;
        end
    end

    gpr_line_buffer #(
        .MAX_WIDTH (MAX_WIDTH),
        .PW        (PW)
    ) u_lines (
        .aclk    (aclk),
        .en      (accept),
        .addr    (col_reg),
        .wr_bank (row_reg[1:0]),
        .wr_data (pix),
        .rd_data (bank_rd)
    );

    gpr_sequencer #(
        .MAX_WIDTH (MAX_WIDTH),
        .PW        (PW)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .width       (width_reg),
        .height      (height_reg),
        .p_valid     (p_valid_reg),
        .p_pix       (p_pix_reg),
        .p_col       (p_col_reg),
        .p_row       (p_row_reg),
        .p_tx        (p_tx_reg),
        .p_ty        (p_ty_reg),
        .bank_rd     (bank_rd),
        .a_ready     (rdy_a),
        .p_take      (p_take),
        .issue       (issue),
        .last_of_run (seq_last),
        .image_done  (seq_done),
        .taps        (taps),
        .win         (win)
    );

    assign rdy_d = !vd_reg || m_ready;
    assign rdy_c = !vc_reg || rdy_d;
    assign rdy_b = !vb_reg || rdy_c;
    assign rdy_a = !va_reg || rdy_b;

    assign lane_ctrl.en_a = rdy_a;
    assign lane_ctrl.en_b = rdy_b;
    assign lane_ctrl.en_c = rdy_c;
    assign lane_ctrl.en_d = rdy_d;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end else begin
            if (rdy_a) va_reg <= issue;
            if (rdy_b) vb_reg <= va_reg;
            if (rdy_c) vc_reg <= vb_reg;
            if (rdy_d) vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_a) fa_reg <= {seq_done, seq_last};
        if (rdy_b) fb_reg <= fa_reg;
        if (rdy_c) fc_reg <= fb_reg;
        if (rdy_d) fd_reg <= fc_reg;
    end

    for (genvar k = 0; k < 4; k++) begin : g_lane
        if (k < MAX_CHANNELS) begin : g_on
            logic [4:0][4:0][gpr_pkg::PIX_W-1:0] lane_win;

            always_comb begin
                for (int i = 0; i < 5; i++) begin
                    for (int j = 0; j < 5; j++) begin
                        lane_win[i][j] = win[i][j][k*gpr_pkg::PIX_W +: gpr_pkg::PIX_W];
                    end
                end
            end

            gpr_lane u_lane (
                .aclk (aclk),
                .ctrl (lane_ctrl),
                .taps (taps),
                .win  (lane_win),
                .q    (lane_q[k])
            );
        end else begin : g_off
            assign lane_q[k] = '0;
        end
    end

    assign m_valid       = vd_reg;
    assign m_chan0_out   = lane_q[0];
    assign m_chan1_out   = lane_q[1];
    assign m_chan2_out   = lane_q[2];
    assign m_chan3_out   = lane_q[3];
    assign m_last_of_run = fd_reg[0];
    assign m_image_done  = fd_reg[1];

endmodule

// ===== rtl/gpr_line_buffer.sv =====
module gpr_line_buffer #(
    parameter int MAX_WIDTH = gpr_pkg::MAX_WIDTH_DEF,
    parameter int PW        = 64
) (
    input  logic                         aclk,
    input  logic                         en,
    input  logic [$clog2(MAX_WIDTH)-1:0] addr,
    input  logic [1:0]                   wr_bank,
    input  logic [PW-1:0]                wr_data,
    output logic [3:0][PW-1:0]           rd_data
);

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [PW-1:0] mem [MAX_WIDTH];

        always_ff @(posedge aclk) begin
            if (en) begin
                rd_data[b] <= mem[addr];
                if (wr_bank == 2'(b)) begin
                    mem[addr] <= wr_data;
                end
            end
        end
    end

endmodule

// ===== rtl/gpr_sequencer.sv =====
module gpr_sequencer #(
    parameter int MAX_WIDTH = gpr_pkg::MAX_WIDTH_DEF,
    parameter int PW        = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]     width,
    input  logic [gpr_pkg::HGT_W-1:0]          height,
    input  logic                               p_valid,
    input  logic [PW-1:0]                      p_pix,
    input  logic [$clog2(MAX_WIDTH)-1:0]       p_col,
    input  logic [gpr_pkg::ROW_W-1:0]          p_row,
    input  gpr_pkg::trig_t                     p_tx,
    input  gpr_pkg::trig_t                     p_ty,
    input  logic [3:0][PW-1:0]                 bank_rd,
    input  logic                               a_ready,
    output logic                               p_take,
    output logic                               issue,
    output logic                               last_of_run,
    output logic                               image_done,
    output gpr_pkg::tap_t                      taps,
    output logic [4:0][4:0][PW-1:0]            win
);

    localparam int CB = $clog2(MAX_WIDTH);
    localparam int PW_ = gpr_pkg::POS_W;

    logic [4:0][4:0][PW-1:0] win_reg;
    logic                    job_valid_reg;
    logic [PW_-1:0]          jx_reg;
    logic [PW_-1:0]          jy_reg;
    logic [PW_-1:0]          jxlo_reg;
    logic [PW_-1:0]          jxhi_reg;
    logic [PW_-1:0]          jyhi_reg;
    logic [CB-1:0]           jcol_reg;
    logic [gpr_pkg::ROW_W-1:0] jrow_reg;

    logic [4:0][PW-1:0] col;
    logic               job_last;
    logic [13:0]        wp1;
    logic [13:0]        hp1;
    logic [PW_-1:0]     xlast;
    logic [PW_-1:0]     ylast;

    assign job_last = (jx_reg == jxhi_reg) && (jy_reg == jyhi_reg);
    assign issue    = job_valid_reg && a_ready;
    assign p_take   = p_valid && (!job_valid_reg || (issue && job_last));
    assign win      = win_reg;

    assign wp1   = 14'(width) + 14'd1;
    assign hp1   = 14'(height) + 14'd1;
    assign xlast = PW_'(wp1 >> 1) - PW_'(1);
    assign ylast = PW_'(hp1 >> 1) - PW_'(1);

    assign last_of_run = job_last;
    assign image_done  = (jy_reg == ylast) && (jx_reg == xlast);

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            col[i] = bank_rd[2'(p_row[1:0] + 2'(i))];
        end
        col[4] = p_pix;
    end

    always_comb begin
        gpr_pkg::tap1_t t;
        for (int n = 0; n < 5; n++) begin
            t = gpr_pkg::reflect_tap($signed({2'b00, jx_reg, 1'b0}) + 16'(n - 2),
                                     16'(width), 16'(jcol_reg));
            taps.co[n] = t.o;
            taps.ce[n] = t.e;
            taps.cm[n] = t.m;
            t = gpr_pkg::reflect_tap($signed({2'b00, jy_reg, 1'b0}) + 16'(n - 2),
                                     16'(height), 16'(jrow_reg));
            taps.ro[n] = t.o;
            taps.re[n] = t.e;
            taps.rm[n] = t.m;
        end
    end

    always_ff @(posedge aclk) begin
        if (p_take) begin
            for (int i = 0; i < 5; i++) begin
                for (int j = 0; j < 4; j++) begin
                    win_reg[i][j] <= win_reg[i][j+1];
                end
                win_reg[i][4] <= col[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
        end else if (p_take) begin
            job_valid_reg <= p_tx.hit && p_ty.hit;
        end else if (issue && job_last) begin
            job_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p_take) begin
            jx_reg   <= p_tx.lo;
            jy_reg   <= p_ty.lo;
            jxlo_reg <= p_tx.lo;
            jxhi_reg <= p_tx.hi;
            jyhi_reg <= p_ty.hi;
            jcol_reg <= p_col;
            jrow_reg <= p_row;
        end else if (issue) begin
            if (jx_reg == jxhi_reg) begin
                jx_reg <= jxlo_reg;
                jy_reg <= jy_reg + PW_'(1);
            end else begin
                jx_reg <= jx_reg + PW_'(1);
            end
        end
    end

endmodule

// ===== rtl/gpr_lane.sv =====
module gpr_lane (
    input  logic                                  aclk,
    input  gpr_pkg::lane_ctrl_t                   ctrl,
    input  gpr_pkg::tap_t                         taps,
    input  logic [4:0][4:0][gpr_pkg::PIX_W-1:0]   win,
    output logic signed [gpr_pkg::OUT_W-1:0]      q
);

    logic signed [4:0][4:0][17:0] v_reg;
    logic signed [4:0][34:0]      rs_reg;
    logic signed [4:0][51:0]      pc_reg;

    logic signed [4:0][4:0][17:0] v_next;
    logic signed [4:0][34:0]      rs_next;
    logic signed [4:0][51:0]      pc_next;
    logic signed [51:0]           sum;
    logic signed [19:0]           rnd;
    logic signed [17:0]           q_next;

    always_comb begin
        logic [15:0] a;
        logic [15:0] b;
        for (int m = 0; m < 5; m++) begin
            for (int n = 0; n < 5; n++) begin
                a = win[taps.re[m]][taps.ce[n]];
                b = win[taps.rm[m]][taps.cm[n]];
                if (taps.co[n] || taps.ro[m]) begin
                    v_next[m][n] = $signed({1'b0, a, 1'b0}) - $signed({2'b00, b});
                end else begin
                    v_next[m][n] = $signed({2'b00, a});
                end
            end
        end
    end

    always_comb begin
        for (int m = 0; m < 5; m++) begin
            rs_next[m] = '0;
            for (int n = 0; n < 5; n++) begin
                rs_next[m] = rs_next[m]
                    + 35'($signed(v_reg[m][n]) * $signed({1'b0, gpr_pkg::TAP_WT[n]}));
            end
            pc_next[m] = 52'($signed(rs_reg[m]) * $signed({1'b0, gpr_pkg::TAP_WT[m]}));
        end
    end

    always_comb begin
        sum = 52'sd2147483648;
        for (int m = 0; m < 5; m++) begin
            sum = sum + $signed(pc_reg[m]);
        end
        rnd = 20'(sum >>> 32);
        if (rnd > 20'sd131071) begin
            q_next = 18'sd131071;
        end else if (rnd < -20'sd131072) begin
            q_next = -18'sd131072;
        end else begin
            q_next = rnd[17:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en_a) begin
            v_reg <= v_next;
        end
        if (ctrl.en_b) begin
            rs_reg <= rs_next;
        end
        if (ctrl.en_c) begin
            pc_reg <= pc_next;
        end
        if (ctrl.en_d) begin
            q <= q_next;
        end
    end

endmodule
